/* rtl/core/mapd_pkg.sv */
// shared types, constants and helpers of the audio presence detector
package mapd_pkg;

    // fixed field widths
    localparam int MAX_CHANNELS = 8;
    localparam int ADC_BITS     = 10;
    localparam int THR_BITS     = 10;
    localparam int MASK_BITS    = 8;

    // defaults of the top level parameters
    localparam int WINDOW_DEPTH_DEFAULT  = 30;
    localparam int CHANNEL_COUNT_DEFAULT = 8;
    localparam int SAMPLE_BITS_DEFAULT   = 10;

    // reset values
    localparam int BASELINE_RESET  = 550;
    localparam int THRESHOLD_RESET = 10;

    typedef logic [ADC_BITS-1:0]  adc_word_t;
    typedef logic [THR_BITS-1:0]  thr_t;
    typedef logic [MASK_BITS-1:0] mask_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

    // mask position of an adc channel: pairs in reverse order, left then right
    function automatic logic [2:0] mask_bit_of(input int adc);
        logic [2:0] a;
        a = 3'(adc);
        return 3'd6 - {a[2:1], 1'b0} + {2'b00, a[0]};
    endfunction

endpackage

/* rtl/core/mapd_ifs.sv */
// item channels of the audio presence detector

// one frame of adc samples
interface mapd_frame_if;
    logic                valid;
    logic                ready;
    mapd_pkg::adc_word_t adc0_sample;
    mapd_pkg::adc_word_t adc1_sample;
    mapd_pkg::adc_word_t adc2_sample;
    mapd_pkg::adc_word_t adc3_sample;
    mapd_pkg::adc_word_t adc4_sample;
    mapd_pkg::adc_word_t adc5_sample;
    mapd_pkg::adc_word_t adc6_sample;
    mapd_pkg::adc_word_t adc7_sample;

    modport source (
        output valid, adc0_sample, adc1_sample, adc2_sample, adc3_sample,
               adc4_sample, adc5_sample, adc6_sample, adc7_sample,
        input  ready
    );
    modport sink (
        input  valid, adc0_sample, adc1_sample, adc2_sample, adc3_sample,
               adc4_sample, adc5_sample, adc6_sample, adc7_sample,
        output ready
    );
endinterface

// one presence result
interface mapd_result_if;
    logic            valid;
    logic            ready;
    mapd_pkg::mask_t active_mask;
    logic            mask_changed;

    modport source (
        output valid, active_mask, mask_changed,
        input  ready
    );
    modport sink (
        input  valid, active_mask, mask_changed,
        output ready
    );
endinterface

/* rtl/core/mapd_ctrl.sv */
// sequencing state machine of the audio presence detector
module mapd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mapd_pkg::dp_status_t status,
    output mapd_pkg::ctrl_cmd_t  cmd
);
    import mapd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.load_out = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // an accepted item always starts a ring scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.scan_step)
        else $error("scan did not follow item capture");

    // a result is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (status.out_free && !in_ready))
        else $error("result loaded into a busy output register");

endmodule

/* rtl/core/mapd_datapath.sv */
// ring memory, peak scan, baselines and result register of the detector
module mapd_datapath #(
    parameter int WINDOW_DEPTH  = mapd_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int CHANNEL_COUNT = mapd_pkg::CHANNEL_COUNT_DEFAULT,
    parameter int SAMPLE_BITS   = mapd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mapd_pkg::ctrl_cmd_t  cmd,
    output mapd_pkg::dp_status_t status,
    input  logic                 cfg_wr_en,
    input  mapd_pkg::thr_t       cfg_wr_data,
    input  mapd_pkg::adc_word_t  frame_samples [mapd_pkg::MAX_CHANNELS],
    input  logic                 out_ready,
    output logic                 out_valid,
    output mapd_pkg::mask_t      out_mask,
    output logic                 out_changed
);
    import mapd_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int RW = CHANNEL_COUNT * SAMPLE_BITS;
    localparam int BW = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

    logic [RW-1:0]           ring_mem [WINDOW_DEPTH];
    logic [RW-1:0]           wr_row;
    logic [RW-1:0]           rd_row_reg;
    logic                    rd_ok_reg;
    logic                    rd_pend_reg;
    logic [WINDOW_DEPTH-1:0] row_valid_reg;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           pos_next;
    logic [AW-1:0]           scan_addr_reg;
    logic [SAMPLE_BITS-1:0]  peak_reg [CHANNEL_COUNT];
    logic [BW-1:0]           base_reg [CHANNEL_COUNT];
    logic [BW-1:0]           base_next [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] active;
    thr_t                    thr_reg;
    mask_t                   prev_mask_reg;
    mask_t                   mask_next;
    logic                    out_valid_reg;
    mask_t                   out_mask_reg;
    logic                    out_changed_reg;

    // incoming frame as one memory row, samples cut to the stored width
    always_comb
    begin
        wr_row = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            wr_row[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(frame_samples[c]);
        end
    end

    // ring memory: one row per window slot, all channels side by side
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ring_mem[pos_reg] <= wr_row;
        end
        if (cmd.scan_step)
        begin
            rd_row_reg <= ring_mem[scan_addr_reg];
        end
    end

    // row valid bits, read flags and scan address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            scan_addr_reg <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_step;
            if (cmd.capture)
            begin
                row_valid_reg[pos_reg] <= 1'b1;
                scan_addr_reg          <= '0;
            end
            else if (cmd.scan_step)
            begin
                rd_ok_reg <= row_valid_reg[scan_addr_reg];
                if (scan_addr_reg != LAST_ADDR)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
            end
        end
    end

    // per channel running peak; a never written slot reads as all ones
    for (genvar c = 0; c < CHANNEL_COUNT; c++)
    begin : g_peak
        logic [SAMPLE_BITS-1:0] rd_sample;

        assign rd_sample = rd_ok_reg ? rd_row_reg[c*SAMPLE_BITS +: SAMPLE_BITS] : '1;

        always_ff @(posedge clk)
        begin
            if (cmd.capture)
            begin
                peak_reg[c] <= '0;
            end
            else if (rd_pend_reg && (rd_sample > peak_reg[c]))
            begin
                peak_reg[c] <= rd_sample;
            end
        end

        // baseline falls to the peak, then compare the rise with the threshold
        always_comb
        begin
            if (BW'(peak_reg[c]) < base_reg[c])
            begin
                base_next[c] = BW'(peak_reg[c]);
            end
            else
            begin
                base_next[c] = base_reg[c];
            end
            active[c] = (BW'(peak_reg[c]) - base_next[c]) > BW'(thr_reg);
        end
    end

    // mask bit placement by adc pair
    always_comb
    begin
        mask_next = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            mask_next[mask_bit_of(c)] = active[c];
        end
    end

    assign pos_next = (pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;

    // threshold, baselines, position, previous mask and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= thr_t'(THRESHOLD_RESET);
            pos_reg         <= '0;
            prev_mask_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_mask_reg    <= '0;
            out_changed_reg <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                base_reg[c] <= BW'(BASELINE_RESET);
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.load_out)
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    base_reg[c] <= base_next[c];
                end
                pos_reg         <= pos_next;
                prev_mask_reg   <= mask_next;
                out_mask_reg    <= mask_next;
                out_changed_reg <= (mask_next != prev_mask_reg);
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.scan_last = (scan_addr_reg == LAST_ADDR);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_mask         = out_mask_reg;
    assign out_changed      = out_changed_reg;

    // a written slot is marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> row_valid_reg[$past(pos_reg)])
        else $error("written ring slot not marked valid");

    // the change flag compares against the mask of the item before
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (out_changed_reg == (out_mask_reg != $past(prev_mask_reg))))
        else $error("mask change flag wrong");

    // every scan starts from the first slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (scan_addr_reg == '0))
        else $error("scan does not start at slot zero");

endmodule

/* rtl/core/multichannel_audio_presence_detect_unit.sv */
// top level of the multichannel audio presence detector
//
// in_frame carries one item per frame: adc0_sample .. adc7_sample, one peak
// sample per adc channel. Each sample enters its channel's ring of the last
// WINDOW_DEPTH samples; the ring peak is compared with a per channel baseline
// that only falls, and a channel is active when the rise exceeds the
// threshold written on cfg_wr_en / cfg_wr_data (reset value 10).
// result carries active_mask and mask_changed, one item per frame.
// An item passes through these steps in order: writing the frame into the ring
// memory, one read per ring slot across all channels in parallel, draining
// the registered read, and updating the baselines and loading the output
// register. The block is ready for the next frame once the result has been
// loaded; it takes no new frame while one is still being scanned, as the
// single read port of the ring memory reads one slot at a time.
// The output register parts the two sides: a frame can be scanned while the
// previous result waits; a stalled receiver holds the block only in its last
// step. Reset marks every ring slot as never written (reads as all ones),
// sets baselines to 550, the previous mask to zero and the ring position to 0.
module multichannel_audio_presence_detect_unit #(
    parameter int WINDOW_DEPTH  = mapd_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int CHANNEL_COUNT = mapd_pkg::CHANNEL_COUNT_DEFAULT,
    parameter int SAMPLE_BITS   = mapd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    mapd_frame_if.sink     in_frame,
    mapd_result_if.source  result,
    input  logic           cfg_wr_en,
    input  mapd_pkg::thr_t cfg_wr_data
);
    import mapd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    adc_word_t  frame_samples [MAX_CHANNELS];

    // frame fields in channel order
    assign frame_samples[0] = in_frame.adc0_sample;
    assign frame_samples[1] = in_frame.adc1_sample;
    assign frame_samples[2] = in_frame.adc2_sample;
    assign frame_samples[3] = in_frame.adc3_sample;
    assign frame_samples[4] = in_frame.adc4_sample;
    assign frame_samples[5] = in_frame.adc5_sample;
    assign frame_samples[6] = in_frame.adc6_sample;
    assign frame_samples[7] = in_frame.adc7_sample;

    // sequencer
    mapd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_frame.valid),
        .in_ready (in_frame.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // ring memory and evaluation
    mapd_datapath #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .frame_samples (frame_samples),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .out_mask      (result.active_mask),
        .out_changed   (result.mask_changed)
    );

endmodule

/* tb/tb_multichannel_audio_presence_detect_unit.sv */
// self-checking testbench of the multichannel audio presence detector
module tb_multichannel_audio_presence_detect_unit;

    import mapd_pkg::*;

    localparam int   DEPTH            = WINDOW_DEPTH_DEFAULT;
    localparam int   CHANNELS         = CHANNEL_COUNT_DEFAULT;
    localparam int   SAMPLE_MAX       = (1 << ADC_BITS) - 1;
    localparam thr_t THR_MAX          = '1;
    localparam int   ITEM_CYCLES      = DEPTH + 3;
    localparam int   LONG_HOLD        = 400;
    localparam int   PHASES           = 6;
    localparam int   FRAMES_PER_PHASE = 250;
    localparam int   DIRECTED_COUNT   = 18;

    typedef adc_word_t [CHANNELS-1:0] frame_t;

    typedef struct packed {
        mask_t active_mask;
        logic  mask_changed;
    } presence_t;

    typedef enum logic {ROW_FRAME, ROW_THRESHOLD} row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        thr_t      thr;
        frame_t    samples;
        logic      typed;
        mask_t     want_mask;
        logic      want_changed;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    thr_t cfg_wr_data;

    mapd_frame_if  frame_ch ();
    mapd_result_if result_ch ();

    multichannel_audio_presence_detect_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_frame    (frame_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state: sample windows, write slot, falling floors, last mask
    adc_word_t sample_window [CHANNELS][DEPTH];
    int        window_slot;
    adc_word_t floor_level [CHANNELS];
    mask_t     last_mask;
    thr_t      threshold_now;

    presence_t pending_presence [$];

    // random scene state: per channel quiet floor and loudness of the scene
    int quiet_level [CHANNELS];
    int loud_span [CHANNELS];
    int scene_left;

    int  mismatches;
    int  frames_sent;
    int  results_seen;
    int  settings_used;
    int  holds_done;
    int  hold_left;
    bit  hold_request;

    // directed items: expectations typed in where they are obvious
    dir_row_t directed_rows [DIRECTED_COUNT] = '{
        // rings still hold all ones, so every channel reads active
        '{ROW_FRAME, 10'd0, {8{10'd0}}, 1'b1, 8'hFF, 1'b1},
        '{ROW_FRAME, 10'd0, {8{10'h3FF}}, 1'b1, 8'hFF, 1'b0},
        '{ROW_FRAME, 10'd0, {4{10'h2AA, 10'h155}}, 1'b1, 8'hFF, 1'b0},
        // highest threshold: nothing can rise above it
        '{ROW_THRESHOLD, 10'h3FF, {8{10'd0}}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd0}}, 1'b1, 8'h00, 1'b1},
        // rise of 473 equal to the threshold is not enough
        '{ROW_THRESHOLD, 10'd473, {8{10'd0}}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd550}}, 1'b1, 8'h00, 1'b0},
        '{ROW_THRESHOLD, 10'd472, {8{10'd0}}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd549}}, 1'b1, 8'hFF, 1'b1},
        // lowest threshold
        '{ROW_THRESHOLD, 10'd0, {8{10'd0}}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd551}}, 1'b1, 8'hFF, 1'b0},
        '{ROW_THRESHOLD, 10'd10, {8{10'd0}}, 1'b0, 8'h00, 1'b0},
        // mixed extremes and walking bits, left to the predictor
        '{ROW_FRAME, 10'd0, {10'd0, 10'd1023, 10'd1, 10'd1022,
                             10'd512, 10'd511, 10'd549, 10'd550}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd1}}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {10'h200, 10'h100, 10'h080, 10'h040,
                             10'h020, 10'h010, 10'h008, 10'h004}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {10'h001, 10'h002, 10'h3FE, 10'h3FD,
                             10'h3FB, 10'h3F7, 10'h3EF, 10'h3DF}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd600}}, 1'b0, 8'h00, 1'b0},
        '{ROW_FRAME, 10'd0, {8{10'd300}}, 1'b0, 8'h00, 1'b0}
    };

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mismatch report, printing capped
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 30)
        begin
            $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
        end
    endtask

    // expected presence result of one frame, advancing the predictor state
    function automatic presence_t predict_presence(input frame_t f);
        presence_t outcome;
        adc_word_t peak;
        int        bitpos;
        outcome.active_mask = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sample_window[c][window_slot] = f[c];
            peak = '0;
            for (int k = 0; k < DEPTH; k++)
            begin
                if (sample_window[c][k] > peak)
                    peak = sample_window[c][k];
            end
            if (peak < floor_level[c])
                floor_level[c] = peak;
            // pairs in reverse order, left channel on the even bit
            bitpos = (3 - c / 2) * 2 + (c % 2);
            if ((peak - floor_level[c]) > threshold_now)
                outcome.active_mask[bitpos] = 1'b1;
        end
        window_slot = (window_slot + 1) % DEPTH;
        outcome.mask_changed = (outcome.active_mask != last_mask);
        last_mask = outcome.active_mask;
        return outcome;
    endfunction

    // scene based frame: quiet floors with loud bursts, some pure noise
    function automatic void make_scene_frame(output frame_t f);
        int v;
        if (scene_left == 0)
        begin
            scene_left = $urandom_range(10, 90);
            for (int c = 0; c < CHANNELS; c++)
            begin
                loud_span[c] = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 400) : 0;
                if ($urandom_range(0, 7) == 0)
                    quiet_level[c] = $urandom_range(0, SAMPLE_MAX);
            end
        end
        scene_left--;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, SAMPLE_MAX);
            else
                v = quiet_level[c] + $urandom_range(0, 3)
                    + ((loud_span[c] > 0) ? $urandom_range(0, loud_span[c]) : 0);
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            f[c] = adc_word_t'(v);
        end
    endfunction

    // offer one frame and wait for it to be taken
    task automatic send_frame(input frame_t f, input logic typed, input presence_t typed_want);
        presence_t want;
        frame_ch.valid       <= 1'b1;
        frame_ch.adc0_sample <= f[0];
        frame_ch.adc1_sample <= f[1];
        frame_ch.adc2_sample <= f[2];
        frame_ch.adc3_sample <= f[3];
        frame_ch.adc4_sample <= f[4];
        frame_ch.adc5_sample <= f[5];
        frame_ch.adc6_sample <= f[6];
        frame_ch.adc7_sample <= f[7];
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        want = predict_presence(f);
        if (typed)
            want = typed_want;
        pending_presence.push_back(want);
        frames_sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_results_clear();
        frame_ch.valid <= 1'b0;
        while (pending_presence.size() != 0)
            @(posedge clk);
    endtask

    // threshold write, one cycle of enable, then the task idles with the enable low before returning
    task automatic write_threshold(input thr_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        threshold_now = v;
        settings_used++;
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        frame_t    f;
        thr_t      thr;
        int        burst_left;
        presence_t typed_want;

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        frame_ch.valid       = 1'b0;
        frame_ch.adc0_sample = '0;
        frame_ch.adc1_sample = '0;
        frame_ch.adc2_sample = '0;
        frame_ch.adc3_sample = '0;
        frame_ch.adc4_sample = '0;
        frame_ch.adc5_sample = '0;
        frame_ch.adc6_sample = '0;
        frame_ch.adc7_sample = '0;
        hold_request         = 1'b0;

        // predictor after reset
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int k = 0; k < DEPTH; k++)
                sample_window[c][k] = adc_word_t'(SAMPLE_MAX);
            floor_level[c] = adc_word_t'(BASELINE_RESET);
            quiet_level[c] = $urandom_range(0, 700);
            loud_span[c]   = 0;
        end
        window_slot   = 0;
        last_mask     = '0;
        threshold_now = thr_t'(THRESHOLD_RESET);
        scene_left    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            if (directed_rows[r].kind == ROW_THRESHOLD)
            begin
                wait_results_clear();
                write_threshold(directed_rows[r].thr);
            end
            else
            begin
                typed_want.active_mask  = directed_rows[r].want_mask;
                typed_want.mask_changed = directed_rows[r].want_changed;
                send_frame(directed_rows[r].samples, directed_rows[r].typed, typed_want);
            end
        end

        // random part in phases, one threshold per phase
        burst_left = $urandom_range(1, 6);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_results_clear();
            case (ph)
                0:       thr = THR_MAX;
                1:       thr = '0;
                4:       thr = thr_t'($urandom_range(0, SAMPLE_MAX));
                5:       thr = thr_t'(THRESHOLD_RESET);
                default: thr = thr_t'($urandom_range(0, 40));
            endcase
            write_threshold(thr);
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                // long receiver hold-off while frames keep coming
                if ((ph == 2 || ph == 4) && n == 100)
                    hold_request = 1'b1;
                make_scene_frame(f);
                send_frame(f, 1'b0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    frame_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 45)) @(posedge clk);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 6);
                end
            end
        end

        // drain and let the block settle
        wait_results_clear();
        repeat (ITEM_CYCLES + 10) @(posedge clk);

        $display("covered %0d frames over %0d threshold settings, %0d results compared",
                 frames_sent, settings_used, results_seen);
        $display("receiver held off %0d times for %0d cycles each, %0d mismatches",
                 holds_done, LONG_HOLD, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver: changing stall patterns, long hold-off on request
    initial
    begin
        rx_mode_e mode;
        int       run_left;
        int       cyc;
        result_ch.ready = 1'b0;
        mode            = RX_OPEN;
        run_left        = 0;
        cyc             = 0;
        hold_left       = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = rx_mode_e'($urandom_range(0, 3));
                    run_left = $urandom_range(20, 200);
                end
                run_left--;
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_COMB:   result_ch.ready <= ((cyc % 5) != 0);
                    default:   result_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // result checker against the oldest expectation
    always @(posedge clk)
    begin
        presence_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_presence.size() == 0)
            begin
                report_mismatch("result with nothing expected", result_ch.active_mask, 0);
            end
            else
            begin
                want = pending_presence.pop_front();
                results_seen++;
                if (result_ch.active_mask !== want.active_mask)
                    report_mismatch("active_mask", result_ch.active_mask, want.active_mask);
                if (result_ch.mask_changed !== want.mask_changed)
                    report_mismatch("mask_changed", result_ch.mask_changed,
                                    want.mask_changed);
            end
        end
    end

    // overall time limit
    initial
    begin
        #15000000;
        $display("timeout with %0d results outstanding", pending_presence.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* multichannel_audio_presence_detect_unit.f */
rtl/core/mapd_pkg.sv
rtl/core/mapd_ifs.sv
rtl/core/mapd_ctrl.sv
rtl/core/mapd_datapath.sv
rtl/core/multichannel_audio_presence_detect_unit.sv
tb/tb_multichannel_audio_presence_detect_unit.sv
